FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define WVA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wva assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define WVA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wva assertion failed");

`endif

FILE: sv/wva_pkg.sv
`timescale 1ns / 1ps
package wva_pkg;

    localparam int POSITIONS_DEF = 1024;
    localparam int LEVELS        = 256;
    localparam logic [7:0] LEVEL_MAX = 8'hFF;

    // request kinds on the input tuser
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_READ   = 2'd1,
        OP_FRAME  = 2'd2,
        OP_PEAK   = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_INTENSITY  = 2'd0,
        CFG_MIRROR     = 2'd1,
        CFG_ENV_MODE   = 2'd2,
        CFG_BACKGROUND = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [7:0] intensity;
        logic       mirror;
        logic [1:0] env_mode;
        logic [7:0] background;
    } cfg_t;

    // one classified request in the queue
    typedef struct packed {
        op_t        op;
        logic [9:0] pos;
        logic [7:0] level;     // display level for samples and reads
        logic       in_range;
    } item_t;

    // back to front handshake
    typedef struct packed {
        logic pop;
        logic init_done;
    } back_ctl_t;

endpackage

FILE: sv/wva_ram.sv
`timescale 1ns / 1ps
module wva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/wva_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wva_front
    import wva_pkg::*;
#(
    parameter int POSITIONS = POSITIONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  back_ctl_t   ctl,
    output cfg_t        cfg,
    output logic        q_valid,
    output item_t       q_head
);

    cfg_t        cfg_reg;
    item_t       q_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    item_t       item;
    logic [15:0] pos_w;
    logic [7:0]  lvl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{intensity: 8'd10, mirror: 1'b1, env_mode: 2'd0,
                         background: 8'd0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_INTENSITY:  cfg_reg.intensity  <= cfg_wdata;
                CFG_MIRROR:     cfg_reg.mirror     <= cfg_wdata[0];
                CFG_ENV_MODE:   cfg_reg.env_mode   <= cfg_wdata[1:0];
                CFG_BACKGROUND: cfg_reg.background <= cfg_wdata;
                default: ;
            endcase
        end
    end
    assign cfg = cfg_reg;

    // classify: range check, mirror for samples
    always_comb
    begin
        pos_w = {6'd0, s_tdata[9:0]};
        lvl   = s_tdata[17:10];
        item.op       = op_t'(s_tuser);
        item.pos      = s_tdata[9:0];
        item.in_range = pos_w < 16'(POSITIONS);
        item.level    = (item.op == OP_SAMPLE && cfg_reg.mirror) ? (LEVEL_MAX - lvl) : lvl;
    end

    assign s_tready = (cnt_reg != 2'd2) && ctl.init_done;
    // out of range samples do nothing, so they never enter the queue
    assign push = s_tvalid && s_tready && !(item.op == OP_SAMPLE && !item.in_range);

    // two-entry queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(ctl.pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    assign q_valid = cnt_reg != 2'd0;
    assign q_head  = q_reg[rd_ptr_reg];

    `WVA_ASSERT_IMP(a_pop_nonempty, ctl.pop, cnt_reg != 2'd0)
    `WVA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg != 2'd3)

endmodule

FILE: sv/wva_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wva_back
    import wva_pkg::*;
#(
    parameter int POSITIONS = POSITIONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  item_t       q_head,
    output back_ctl_t   ctl,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata
);

    localparam int PW    = $clog2(POSITIONS);
    localparam int CELLS = POSITIONS * LEVELS;
    localparam int CAW   = PW + 8;

    state_t          state_reg, state_next;
    logic [CAW-1:0]  cnt_reg, cnt_next;
    logic            clr_cells_reg, clr_cells_next;
    logic            clr_env_reg, clr_env_next;
    logic            clr_peak_reg, clr_peak_next;
    logic            init_done_reg, init_done_next;
    logic [7:0]      bg_reg, bg_next;
    op_t             op_reg, op_next;
    logic [PW-1:0]   pidx_reg, pidx_next;
    logic [7:0]      lvl_reg, lvl_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_val_reg, out_val_next;
    logic            out_mark_reg, out_mark_next;

    logic [15:0]     head_pos_w;
    logic [PW-1:0]   head_pidx;
    logic            can_pop, sweep_last, sweep_low;

    logic            cell_we, env_we, peak_we;
    logic [CAW-1:0]  cell_waddr, cell_raddr;
    logic [PW-1:0]   pos_waddr, pos_raddr;
    logic [7:0]      cell_wdata, cell_rdata;
    logic [16:0]     env_wdata, env_rdata;
    logic [15:0]     peak_wdata, peak_rdata;

    logic            hit;
    logic [7:0]      fmin, fmax, pmin, pmax;
    logic [8:0]      sum;
    logic            mark;

    assign head_pos_w = {6'd0, q_head.pos};
    assign head_pidx  = head_pos_w[PW-1:0];
    assign can_pop    = q_valid && (q_head.op != OP_READ || !out_valid_reg);
    assign sweep_low  = cnt_reg < CAW'(POSITIONS);
    assign sweep_last = clr_cells_reg ? (cnt_reg == CAW'(CELLS - 1))
                                      : (cnt_reg == CAW'(POSITIONS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (can_pop)
                begin
                    unique case (q_head.op)
                        OP_SAMPLE: state_next = ST_EXEC;
                        OP_READ:   state_next = q_head.in_range ? ST_EXEC : ST_IDLE;
                        OP_FRAME,
                        OP_PEAK:   state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC:  state_next = ST_IDLE;
            ST_CLEAR: state_next = sweep_last ? ST_IDLE : ST_CLEAR;
            default:  state_next = ST_IDLE;
        endcase
    end

    // unpack stored envelopes and work out the update
    always_comb
    begin
        {hit, fmin, fmax} = env_rdata;
        {pmin, pmax}      = peak_rdata;
        sum  = {1'b0, cell_rdata} + {1'b0, cfg.intensity};
        mark = (cfg.env_mode[0] && hit && (lvl_reg == fmin || lvl_reg == fmax)) ||
               (cfg.env_mode[1] && (lvl_reg == pmin || lvl_reg == pmax));
    end

    // outputs and datapath controls
    always_comb
    begin
        cnt_next       = cnt_reg;
        clr_cells_next = clr_cells_reg;
        clr_env_next   = clr_env_reg;
        clr_peak_next  = clr_peak_reg;
        init_done_next = init_done_reg;
        bg_next        = bg_reg;
        op_next        = op_reg;
        pidx_next      = pidx_reg;
        lvl_next       = lvl_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_val_next   = out_val_reg;
        out_mark_next  = out_mark_reg;
        ctl.pop        = 1'b0;
        ctl.init_done  = init_done_reg;
        cell_we    = 1'b0;
        env_we     = 1'b0;
        peak_we    = 1'b0;
        cell_waddr = {pidx_reg, lvl_reg};
        pos_waddr  = pidx_reg;
        cell_raddr = {head_pidx, q_head.level};
        pos_raddr  = head_pidx;
        cell_wdata = sum[8] ? LEVEL_MAX : sum[7:0];
        env_wdata  = {1'b1,
                      (!hit || lvl_reg < fmin) ? lvl_reg : fmin,
                      (!hit || lvl_reg > fmax) ? lvl_reg : fmax};
        peak_wdata = {(lvl_reg < pmin) ? lvl_reg : pmin,
                      (lvl_reg > pmax) ? lvl_reg : pmax};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (can_pop)
                begin
                    ctl.pop   = 1'b1;
                    op_next   = q_head.op;
                    pidx_next = head_pidx;
                    lvl_next  = q_head.level;
                    cnt_next  = '0;
                    bg_next   = cfg.background;
                    case (q_head.op)
                        OP_READ:
                        begin
                            if (!q_head.in_range)
                            begin
                                out_valid_next = 1'b1;
                                out_val_next   = 8'd0;
                                out_mark_next  = 1'b0;
                            end
                        end
                        OP_FRAME:
                        begin
                            clr_cells_next = 1'b1;
                            clr_env_next   = 1'b1;
                            clr_peak_next  = 1'b0;
                        end
                        OP_PEAK:
                        begin
                            clr_cells_next = 1'b0;
                            clr_env_next   = 1'b0;
                            clr_peak_next  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_SAMPLE)
                begin
                    cell_we = 1'b1;
                    env_we  = 1'b1;
                    peak_we = 1'b1;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = mark ? LEVEL_MAX : cell_rdata;
                    out_mark_next  = mark;
                end
            end
            ST_CLEAR:
            begin
                cell_waddr = cnt_reg;
                pos_waddr  = cnt_reg[PW-1:0];
                cell_wdata = bg_reg;
                env_wdata  = {1'b0, LEVEL_MAX, 8'd0};
                peak_wdata = {LEVEL_MAX, 8'd0};
                cell_we    = clr_cells_reg;
                env_we     = clr_env_reg && sweep_low;
                peak_we    = clr_peak_reg && sweep_low;
                cnt_next   = cnt_reg + CAW'(1);
                if (sweep_last)
                begin
                    init_done_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_cells_reg <= 1'b1;
            clr_env_reg   <= 1'b1;
            clr_peak_reg  <= 1'b1;
            init_done_reg <= 1'b0;
            bg_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_cells_reg <= clr_cells_next;
            clr_env_reg   <= clr_env_next;
            clr_peak_reg  <= clr_peak_next;
            init_done_reg <= init_done_next;
            bg_reg        <= bg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pidx_reg     <= pidx_next;
        lvl_reg      <= lvl_next;
        out_val_reg  <= out_val_next;
        out_mark_reg <= out_mark_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_mark_reg, out_val_reg};

    // wave cells, frame envelope {hit, min, max}, peak envelope {min, max}
    wva_ram #(.WIDTH(8), .DEPTH(CELLS)) u_cells (
        .clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
        .raddr(cell_raddr), .rdata(cell_rdata)
    );
    wva_ram #(.WIDTH(17), .DEPTH(POSITIONS)) u_env (
        .clk(clk), .we(env_we), .waddr(pos_waddr), .wdata(env_wdata),
        .raddr(pos_raddr), .rdata(env_rdata)
    );
    wva_ram #(.WIDTH(16), .DEPTH(POSITIONS)) u_peak (
        .clk(clk), .we(peak_we), .waddr(pos_waddr), .wdata(peak_wdata),
        .raddr(pos_raddr), .rdata(peak_rdata)
    );

    `WVA_ASSERT_NXT(a_exec_returns, state_reg == ST_EXEC, state_reg == ST_IDLE)
    `WVA_ASSERT_IMP(a_pop_idle, ctl.pop, state_reg == ST_IDLE)
    `WVA_ASSERT_IMP(a_cell_write_src, cell_we,
                    state_reg == ST_CLEAR || (state_reg == ST_EXEC && op_reg == OP_SAMPLE))

endmodule

FILE: sv/video_waveform_accumulator_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields
// s_*      in   tuser: req_type[1:0]; tdata: position[9:0], sample_level[17:10]
// m_*      out  tdata: cell_value[7:0], envelope_mark[8]
// cfg_*    in   cfg_addr: register index; cfg_wdata[7:0]
//
// In the back end a sample or an in-range read reads the cell and envelope
// memories as it is dequeued, then writes back or loads the output register.
// Start frame is dequeued, then the cell memory is swept one entry a cycle.
// Reset peak envelope sweeps the peak envelope memory the same way.
// After reset the same full sweep runs with s_tready low.
// A two-entry queue holds requests while the back end works or m_tready is low.
module video_waveform_accumulator_unit
    import wva_pkg::*;
#(
    parameter int POSITIONS = POSITIONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // position[9:0], sample_level[17:10]
    input  logic [1:0]  s_tuser,    // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // cell_value[7:0], envelope_mark[8]
);

    cfg_t      cfg;
    back_ctl_t ctl;
    logic      q_valid;
    item_t     q_head;

    wva_front #(.POSITIONS(POSITIONS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .ctl(ctl), .cfg(cfg),
        .q_valid(q_valid), .q_head(q_head)
    );

    wva_back #(.POSITIONS(POSITIONS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .q_valid(q_valid), .q_head(q_head), .ctl(ctl),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule
